// File: hw/rtl/bb3_pkg.sv
// shared types and constants for the 3x3 box blur stream core
// no dependencies; imported by every module of the block
package bb3_pkg;

	// default buffer geometry
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// configuration port
	localparam int CFG_W  = 11;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

	// word opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// divide by nine as multiply and shift, exact for sums below 4096
	localparam logic [11:0] DIV9_MUL = 12'd3641;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic       op;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       last_of_frame;
	} result_t;

	// per-word decisions taken from the frame counters at accept
	typedef struct packed {
		logic is_pixel;
		logic has_out;
		logic edge_sel;
		logic sel_lower;
		logic interior;
		logic last;
	} ctl_t;

	// pipeline occupancy seen by the top level
	typedef struct packed {
		logic s1_valid;
		logic s1_done;
		logic s2_valid;
		logic s2_adv;
	} pipe_st_t;

endpackage

// File: hw/rtl/bb3_ctrl.sv
// frame position counters and per-word decisions of the box blur core
// depends on bb3_pkg
module bb3_ctrl import bb3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         op,
	input  logic [CFG_W-1:0]             frame_width,
	input  logic [CFG_W-1:0]             frame_height,
	output ctl_t                         ctl,
	output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	output logic [$clog2(MAX_WIDTH)-1:0] edge_addr
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int EW = WW + 1;
	localparam int EH = HW + 1;

	logic [WW-1:0] width_c;
	logic [HW-1:0] height_c;
	logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
	logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
	logic          done_q, done_d;
	logic          in_col_last, in_row_last, out_col_last, out_row_last;
	logic          interior, fire, last, flush_path;

	// clamp the frame size to 1..max
	always_comb begin
		if (frame_width == '0) begin
			width_c = WW'(1);
		end else if (int'(frame_width) > MAX_WIDTH) begin
			width_c = WW'(MAX_WIDTH);
		end else begin
			width_c = WW'(frame_width);
		end
		if (frame_height == '0) begin
			height_c = HW'(1);
		end else if (int'(frame_height) > MAX_HEIGHT) begin
			height_c = HW'(MAX_HEIGHT);
		end else begin
			height_c = HW'(frame_height);
		end
	end

	// position compares
	assign in_col_last  = EW'(in_col_q) + EW'(1) >= EW'(width_c);
	assign in_row_last  = EH'(in_row_q) + EH'(1) >= EH'(height_c);
	assign out_col_last = EW'(out_col_q) + EW'(1) >= EW'(width_c);
	assign out_row_last = EH'(out_row_q) + EH'(1) >= EH'(height_c);
	assign last         = out_row_last && out_col_last;

	assign interior = (out_row_q != '0) && (EH'(out_row_q) + EH'(2) <= EH'(height_c)) &&
			  (out_col_q != '0) && (EW'(out_col_q) + EW'(2) <= EW'(width_c));

	// output trails input by one row plus one pixel
	assign fire = ((in_row_q == '0) && (EW'(in_col_q) > EW'(width_c))) ||
		      ((in_row_q == RW'(1)) && (in_col_q != '0)) ||
		      (EH'(in_row_q) >= EH'(2));

	// once the frame is in, every word drains one pending pixel
	assign flush_path = (op == OP_FLUSH) || done_q;

	assign ctl.is_pixel  = !flush_path;
	assign ctl.has_out   = flush_path ? done_q : fire;
	assign ctl.edge_sel  = (in_col_q == '0);
	assign ctl.sel_lower = out_row_last;
	assign ctl.interior  = !flush_path && interior;
	assign ctl.last      = last;

	assign rd_addr   = flush_path ? out_col_q : in_col_q;
	assign edge_addr = CW'(width_c - WW'(1));

	// next counter values
	always_comb begin
		in_col_d  = in_col_q;
		in_row_d  = in_row_q;
		out_col_d = out_col_q;
		out_row_d = out_row_q;
		done_d    = done_q;
		if (!flush_path) begin
			if (in_col_last) begin
				in_col_d = '0;
				if (in_row_last) begin
					in_row_d = '0;
					done_d   = 1'b1;
				end else begin
					in_row_d = in_row_q + RW'(1);
				end
			end else begin
				in_col_d = in_col_q + CW'(1);
			end
		end
		if (ctl.has_out) begin
			if (last) begin
				out_col_d = '0;
				out_row_d = '0;
				done_d    = 1'b0;
			end else if (out_col_last) begin
				out_col_d = '0;
				out_row_d = out_row_q + RW'(1);
			end else begin
				out_col_d = out_col_q + CW'(1);
			end
		end
	end

	// counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			done_q    <= 1'b0;
		end else if (accept) begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
			done_q    <= done_d;
		end
	end

endmodule

// File: hw/rtl/bb3_lbuf.sv
// two line buffer memories of the box blur core, with registered read
// depends on bb3_pkg; upper buffer has a second read port for the row-end pixel
module bb3_lbuf import bb3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  logic [$clog2(MAX_WIDTH)-1:0] edge_addr,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  rgb_t                         wr_upper,
	input  rgb_t                         wr_lower,
	output rgb_t                         upper_rd,
	output rgb_t                         lower_rd,
	output rgb_t                         edge_rd
);

	rgb_t upper_mem [MAX_WIDTH];
	rgb_t lower_mem [MAX_WIDTH];
	rgb_t upper_rd_q, lower_rd_q, edge_rd_q;

	// upper row: one write port, two read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr] <= wr_upper;
		end
		if (rd_en) begin
			upper_rd_q <= upper_mem[rd_addr];
			edge_rd_q  <= upper_mem[edge_addr];
		end
	end

	// lower row: one write port, one read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			lower_mem[wr_addr] <= wr_lower;
		end
		if (rd_en) begin
			lower_rd_q <= lower_mem[rd_addr];
		end
	end

	assign upper_rd = upper_rd_q;
	assign lower_rd = lower_rd_q;
	assign edge_rd  = edge_rd_q;

endmodule

// File: hw/rtl/bb3_dpath.sv
// window, averaging and output pipeline of the box blur core
// depends on bb3_pkg; takes read data from bb3_lbuf and writes it back
module bb3_dpath import bb3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  rgb_t                         pix,
	input  ctl_t                         ctl,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  logic [$clog2(MAX_WIDTH)-1:0] edge_addr,
	input  rgb_t                         upper_rd,
	input  rgb_t                         lower_rd,
	input  rgb_t                         edge_rd,
	output logic                         wr_en,
	output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	output rgb_t                         wr_upper,
	output rgb_t                         wr_lower,
	input  logic                         result_stall,
	output logic                         result_valid,
	output result_t                      result,
	output pipe_st_t                     st
);

	localparam int CW = $clog2(MAX_WIDTH);

	typedef struct packed {
		logic [9:0] red;
		logic [9:0] green;
		logic [9:0] blue;
	} colsum_t;

	typedef struct packed {
		logic [11:0] red;
		logic [11:0] green;
		logic [11:0] blue;
	} boxsum_t;

	function automatic colsum_t col_add(rgb_t a, rgb_t b, rgb_t c);
		colsum_t s;
		s.red   = 10'(a.red) + 10'(b.red) + 10'(c.red);
		s.green = 10'(a.green) + 10'(b.green) + 10'(c.green);
		s.blue  = 10'(a.blue) + 10'(b.blue) + 10'(c.blue);
		return s;
	endfunction

	function automatic boxsum_t box_add(colsum_t a, colsum_t b, colsum_t c);
		boxsum_t s;
		s.red   = 12'(a.red) + 12'(b.red) + 12'(c.red);
		s.green = 12'(a.green) + 12'(b.green) + 12'(c.green);
		s.blue  = 12'(a.blue) + 12'(b.blue) + 12'(c.blue);
		return s;
	endfunction

	function automatic logic [7:0] div9(logic [11:0] x);
		logic [23:0] p;
		p = 24'(x) * 24'(DIV9_MUL);
		return p[22:15];
	endfunction

	logic          valid_s1, fwd_s1;
	ctl_t          ctl_s1;
	rgb_t          pix_s1;
	logic [CW-1:0] addr_s1, edge_addr_s1;
	logic [CW-1:0] wr_addr_q;
	rgb_t          wr_upper_q, wr_lower_q;
	rgb_t          mid_q;
	colsum_t       cs1_q, cs2_q;
	logic          valid_s2, interior_s2, last_s2;
	boxsum_t       sum_s2;
	rgb_t          pass_s2;
	logic          result_valid_q;
	result_t       result_q;

	logic          hit_a, hit_e, s1_done, s2_adv, s2_free;
	rgb_t          top_v, low_v, edge_v, pass_c;
	colsum_t       colsum_c;
	boxsum_t       sum_c;

	// forward the write that landed on the edge this word was read
	assign hit_a  = fwd_s1 && (wr_addr_q == addr_s1);
	assign hit_e  = fwd_s1 && (wr_addr_q == edge_addr_s1);
	assign top_v  = hit_a ? wr_upper_q : upper_rd;
	assign low_v  = hit_a ? wr_lower_q : lower_rd;
	assign edge_v = hit_e ? wr_upper_q : edge_rd;

	// new window column and box sum
	assign colsum_c = col_add(top_v, low_v, pix_s1);
	assign sum_c    = box_add(cs1_q, cs2_q, colsum_c);

	// pass-through pixel: window center, row-end pixel, or buffered pixel on drain
	always_comb begin
		if (ctl_s1.is_pixel) begin
			pass_c = ctl_s1.edge_sel ? edge_v : mid_q;
		end else begin
			pass_c = ctl_s1.sel_lower ? low_v : top_v;
		end
	end

	// pipeline flow
	assign s2_adv  = !result_valid_q || !result_stall;
	assign s2_free = !valid_s2 || s2_adv;
	assign s1_done = !ctl_s1.has_out || s2_free;

	// line buffer write-back: middle row moves up, new pixel enters below
	assign wr_en    = valid_s1 && s1_done && ctl_s1.is_pixel;
	assign wr_addr  = addr_s1;
	assign wr_upper = low_v;
	assign wr_lower = pix_s1;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			ctl_s1   <= '0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !s1_done);
			if (accept) begin
				fwd_s1 <= wr_en;
				ctl_s1 <= ctl;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= pix;
			addr_s1      <= rd_addr;
			edge_addr_s1 <= edge_addr;
		end
	end

	// copy of the last write for forwarding
	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_addr_q  <= addr_s1;
			wr_upper_q <= low_v;
			wr_lower_q <= pix_s1;
		end
	end

	// window state as column sums plus the center pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs1_q <= '0;
			cs2_q <= '0;
			mid_q <= '0;
		end else if (wr_en) begin
			cs1_q <= cs2_q;
			cs2_q <= colsum_c;
			mid_q <= low_v;
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1 && ctl_s1.has_out;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1 && ctl_s1.has_out) begin
			sum_s2      <= sum_c;
			pass_s2     <= pass_c;
			interior_s2 <= ctl_s1.interior;
			last_s2     <= ctl_s1.last;
		end
	end

	// output register: divide by nine for interior pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s2_adv) begin
			result_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && valid_s2) begin
			result_q.red_out       <= interior_s2 ? div9(sum_s2.red) : pass_s2.red;
			result_q.green_out     <= interior_s2 ? div9(sum_s2.green) : pass_s2.green;
			result_q.blue_out      <= interior_s2 ? div9(sum_s2.blue) : pass_s2.blue;
			result_q.last_of_frame <= last_s2;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign st.s1_valid = valid_s1;
	assign st.s1_done  = s1_done;
	assign st.s2_valid = valid_s2;
	assign st.s2_adv   = s2_adv;

endmodule

// File: hw/rtl/box_blur_3x3_stream_core.sv
// 3x3 box blur over a raster RGB pixel stream: top level with register port
// depends on bb3_pkg, bb3_ctrl, bb3_lbuf, bb3_dpath
//
// Takes one word per clock: a pixel (op 0) or a flush tick (op 1). Interior
// pixels leave as the per-channel truncated average of their 3x3 neighborhood,
// border pixels unchanged; results come in raster order, frame_width + 1 pixels
// behind the input, and once the frame's last pixel is in, each further word
// (flush or pixel, whose pixel is then dropped) drains one pending result, the
// final one flagged last_of_frame. A word passes through stage 1, stage 2 and the
// output register on its way to the output; the rate is one word per cycle while
// the input is not stalled, set by the single
// read-modify-write pass through the two line buffer memories, and the input
// stalls only when the output is held and both internal stages are full. The
// buffers need no clearing pass after reset. Registers: frame_width at byte
// address 0, frame_height at 4, values clamped to 1..MAX_WIDTH / 1..MAX_HEIGHT;
// write them only between frames.
module box_blur_3x3_stream_core import bb3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CFG_W-1:0] frame_width_q, frame_height_q;
	logic             cfg_wr, accept, wr_en;
	ctl_t             ctl;
	pipe_st_t         st;
	rgb_t             pix, upper_rd, lower_rd, edge_rd, wr_upper, wr_lower;
	logic [CW-1:0]    rd_addr, edge_addr, wr_addr;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_W-1:0];
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// word handshake
	assign item_stall = st.s1_valid && !st.s1_done;
	assign accept     = item_valid && !item_stall;
	assign pix.red    = item.red_in;
	assign pix.green  = item.green_in;
	assign pix.blue   = item.blue_in;

	bb3_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.op           (item.op),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.ctl          (ctl),
		.rd_addr      (rd_addr),
		.edge_addr    (edge_addr)
	);

	bb3_lbuf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_lbuf (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (rd_addr),
		.edge_addr (edge_addr),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_upper  (wr_upper),
		.wr_lower  (wr_lower),
		.upper_rd  (upper_rd),
		.lower_rd  (lower_rd),
		.edge_rd   (edge_rd)
	);

	bb3_dpath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.pix          (pix),
		.ctl          (ctl),
		.rd_addr      (rd_addr),
		.edge_addr    (edge_addr),
		.upper_rd     (upper_rd),
		.lower_rd     (lower_rd),
		.edge_rd      (edge_rd),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_upper     (wr_upper),
		.wr_lower     (wr_lower),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.st           (st)
	);

	// input backs up only behind a held output
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled while output is free");

	// a word never lands on an unfinished stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !st.s1_valid || st.s1_done)
		else $error("stage 1 overwritten");

	// an accepted pixel writes back next cycle unless the pipeline holds it
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.is_pixel |=> wr_en || item_stall)
		else $error("pixel lost its line buffer write");

	// stage 2 keeps its word while the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		st.s2_valid && !st.s2_adv |=> st.s2_valid)
		else $error("stage 2 word dropped");

endmodule
